>>> design/olief_pkg.sv
`timescale 1ns / 1ps
package olief_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              ers;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] val;
  } cell_ctrl_t;

endpackage

>>> design/olief_cell.sv
`timescale 1ns / 1ps
module olief_cell
  import olief_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] entry,
  output logic              match
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic [CMP_W-1:0]  idx_w;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;

  assign idx_w = CMP_W'(cell_idx);
  assign pos_w = CMP_W'(ctrl.pos);
  assign cnt_w = CMP_W'(ctrl.count);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (idx_w == pos_w) begin
        entry_nxt = ctrl.val;
      end else if (idx_w > pos_w && idx_w <= cnt_w) begin
        entry_nxt = left_data;
      end
    end else if (ctrl.ers) begin
      // take the right neighbor for every slot from the erased one up to the last but one filled slot
      if (idx_w >= pos_w && (idx_w + CMP_W'(1)) < cnt_w) begin
        entry_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == ctrl.val) && (idx_w < cnt_w);

endmodule

>>> design/olief_prio.sv
`timescale 1ns / 1ps
module olief_prio
  import olief_pkg::*;
(
  input  logic [CAPACITY-1:0] req,
  output logic                hit,
  output logic [IDX_W-1:0]    idx
);

  always_comb begin
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign hit = |req;

endmodule

>>> design/ordered_list_insert_erase_find.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed values held in a chain of cells. A
// command is a transfer when start is high and busy is low; busy never rises,
// so a command may be issued every cycle. Each command gives one result,
// strobed by out_valid for exactly one cycle, the cycle right after the
// command's transfer; the receiver cannot stall it and must take it then.
// Insert and erase shift all entries at once, each cell loading its neighbor,
// and find compares every cell in parallel, so one command completes per
// cycle. Results reflect every earlier command.
module ordered_list_insert_erase_find
  import olief_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [IDX_W-1:0]         out_found_index,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [CNT_W-1:0]         out_count
);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic                    out_valid_r;
  logic [CNT_W-1:0]        fill_cnt_r;
  logic [CNT_W-1:0]        fill_cnt_nxt;
  status_t                 status_r;
  status_t                 status_nxt;
  logic                    is_find_r;
  logic [CAPACITY-1:0]     match_r;
  logic [DATA_W-1:0]       read_r;
  logic [DATA_W-1:0]       read_nxt;

  logic                    acc;
  act_t                    act;
  logic [CMP_W-1:0]        pos_w;
  logic [CMP_W-1:0]        cnt_w;
  cell_ctrl_t              ctrl;

  logic [DATA_W-1:0]       entry_q [CAPACITY];
  logic [CAPACITY-1:0]     match_q;
  logic                    find_hit;
  logic [IDX_W-1:0]        find_idx;

  // Every command is taken in the cycle it is offered; never hold off start.
  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign act  = act_t'(in_action);

  assign pos_w = CMP_W'(in_position);
  assign cnt_w = CMP_W'(fill_cnt_r);

  // ---------------------------------------------------------------------
  // Command decode: status, next count, read value and the shift controls for the chain
  // ---------------------------------------------------------------------
  always_comb begin
    status_nxt   = ST_OK;
    fill_cnt_nxt = fill_cnt_r;
    read_nxt     = '0;
    ctrl.ins     = 1'b0;
    ctrl.ers     = 1'b0;
    ctrl.pos     = in_position;
    ctrl.count   = fill_cnt_r;
    ctrl.val     = in_value;
    case (act)
      ACT_INSERT: begin
        // a full list wins over a bad position
        if (fill_cnt_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.ins     = acc;
          fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
        end
      end
      ACT_ERASE: begin
        if (pos_w >= cnt_w) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.ers     = acc;
          fill_cnt_nxt = fill_cnt_r - CNT_W'(1);
        end
      end
      ACT_FIND: begin
        // resolved in the next cycle from the registered match vector
        status_nxt = ST_OK;
      end
      ACT_READ: begin
        if (pos_w >= cnt_w) begin
          status_nxt = ST_RANGE;
        end else begin
          read_nxt = entry_q[in_position[IDX_W-1:0]];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Chain of cells: shifts load the left or right neighbor, inserts the new value
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = entry_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = entry_q[i+1];
    end

    olief_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .entry      (entry_q[i]),
      .match      (match_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // Result registers: hold the outcome of the last transfer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fill_cnt_r  <= '0;
    end else begin
      out_valid_r <= acc;
      if (acc) begin
        fill_cnt_r <= fill_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      is_find_r <= (act == ACT_FIND);
      match_r   <= match_q;
      read_r    <= read_nxt;
    end
  end

  olief_prio u_prio (
    .req (match_r),
    .hit (find_hit),
    .idx (find_idx)
  );

  // A find reports the lowest matching slot, or missing if none matched.
  always_comb begin
    out_status      = status_r;
    out_found_index = '0;
    if (is_find_r) begin
      if (find_hit) begin
        out_status      = ST_OK;
        out_found_index = find_idx;
      end else begin
        out_status = ST_MISSING;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_r;
  assign out_count      = fill_cnt_r;

`ifndef SYNTHESIS
  a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc))
    else $error("result strobe without a preceding transfer");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == CNT_W'(CAPACITY))
    else $error("full status on a list that is not full");

  a_index_only_on_find: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_index != '0 |-> is_find_r && out_status == ST_OK)
    else $error("found index outside a successful find");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb
  import olief_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 500;   // quiet cycles before giving up
  localparam int MAX_GAP        = 24;    // longest sender pause per transfer

  // One command as the sender sees it; gap is the idle time ahead of it.
  typedef struct {
    act_t                     action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    int unsigned              gap;
  } list_cmd_t;

  // One result as the block should strobe it.
  typedef struct {
    status_t                  status;
    logic [IDX_W-1:0]         found_index;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
  } list_resp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_action = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic [IDX_W-1:0]         out_found_index;
  logic signed [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]         out_count;

  ordered_list_insert_erase_find dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_read_value  (out_read_value),
    .out_count       (out_count)
  );

  always #4 clk = ~clk;

  // Commands waiting to be driven, and results owed by the block, oldest first.
  list_cmd_t  cmd_q[$];
  list_resp_t resp_q[$];

  // Shadow copy of the list contents that the predictor keeps in step.
  logic signed [DATA_W-1:0] shadow_mem [CAPACITY];
  int                       shadow_len = 0;

  // Length the stimulus generator assumes, so that positions land in range.
  int gen_len = 0;

  int errors = 0;
  int n_items = 0;
  int n_taken = 0;
  int gap_cnt = 0;
  int quiet_cycles = 0;
  logic acc_q = 1'b0;      // a command transfer happened at the last rising edge

  // Values drawn often, so that finds hit and duplicates test the lowest match.
  logic signed [DATA_W-1:0] hot_vals [8] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
    32'sd1, 32'sd5, 32'sh5555_aaaa, -32'sd77
  };

  // Apply one command to the shadow list and return the result it must give.
  function automatic list_resp_t apply_list_op(list_cmd_t c);
    list_resp_t r;
    int         p;
    int         i;
    bit         hit;
    r.status      = ST_OK;
    r.found_index = '0;
    r.read_value  = '0;
    p   = int'(c.position);
    hit = 1'b0;
    case (c.action)
      ACT_INSERT: begin
        // A full list is reported ahead of a bad position.
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[p] = c.value;
          shadow_len++;
        end
      end
      ACT_ERASE: begin
        if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
        end
      end
      ACT_FIND: begin
        for (i = 0; i < shadow_len && !hit; i++) begin
          if (shadow_mem[i] == c.value) begin
            hit = 1'b1;
            r.found_index = IDX_W'(i);
          end
        end
        if (!hit) r.status = ST_MISSING;
      end
      default: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_mem[p];
      end
    endcase
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  // Queue one command and track the length it leaves, for later positions.
  task automatic push_cmd(act_t a, int p, logic signed [DATA_W-1:0] v, int unsigned g);
    list_cmd_t c;
    c.action   = a;
    c.position = POS_W'(p);
    c.value    = v;
    c.gap      = g;
    cmd_q.push_back(c);
    if (a == ACT_INSERT && gen_len < CAPACITY && p <= gen_len) gen_len++;
    if (a == ACT_ERASE && p < gen_len) gen_len--;
  endtask

  task automatic diff_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Driver: move to the next command once the current one is a transfer.
  // While idle, put noise on the fields; the block must ignore it.
  always @(negedge clk) begin : drive
    list_cmd_t c;
    bit        load;
    if (rst_n && (!start || acc_q)) begin
      load = (cmd_q.size() > 0) && (gap_cnt >= int'(cmd_q[0].gap));
      if (load) begin
        c = cmd_q.pop_front();
        gap_cnt <= 0;
      end else begin
        c.action   = act_t'($urandom_range(3));
        c.position = POS_W'($urandom);
        c.value    = $urandom;
        c.gap      = 0;
        gap_cnt <= gap_cnt + 1;
      end
      start       <= load;
      in_action   <= c.action;
      in_position <= c.position;
      in_value    <= c.value;
    end
  end

  // Monitor: check the strobed result against the oldest prediction first,
  // then record any command transfer at this edge. The block answers in the
  // cycle after the transfer, so a prediction is never consumed in its own cycle.
  always @(posedge clk) begin : monitor
    list_cmd_t  c;
    list_resp_t want;
    bit         xfer;
    if (rst_n) begin
      xfer = start && !busy;
      if (out_valid) begin
        if (resp_q.size() == 0) begin
          $display("%0t: result mismatch, expected no result, actual status %0d count %0d",
                   $time, out_status, out_count);
          errors++;
        end else begin
          want = resp_q.pop_front();
          diff_field("status", 64'(want.status), 64'(out_status));
          diff_field("found_index", 64'(want.found_index), 64'(out_found_index));
          diff_field("read_value", 64'(want.read_value), 64'(out_read_value));
          diff_field("count", 64'(want.count), 64'(out_count));
        end
      end
      if (xfer) begin
        c.action   = act_t'(in_action);
        c.position = in_position;
        c.value    = in_value;
        c.gap      = 0;
        resp_q.push_back(apply_list_op(c));
        n_taken <= n_taken + 1;
      end
      acc_q <= xfer;
      // Watchdog: any transfer on either side resets the quiet count.
      if (xfer || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          k;
    int          n;
    int          phase;
    int          idle_pct;
    int          mode;
    int          ins_pct;
    int          ers_pct;
    int          roll;
    int          p;
    int unsigned g;
    act_t        a;
    logic signed [DATA_W-1:0] v;

    // Directed: every action on an empty list, insert past the end.
    push_cmd(ACT_READ, 0, 32'sd0, 0);
    push_cmd(ACT_ERASE, 0, 32'sd0, 0);
    push_cmd(ACT_FIND, 0, 32'sd0, 0);
    push_cmd(ACT_INSERT, 1, 32'sd3, 0);
    // Fill to capacity: front, back and middle pushes, extremes, duplicates.
    push_cmd(ACT_INSERT, 0, 32'sh8000_0000, 0);
    push_cmd(ACT_INSERT, 1, 32'sh7fff_ffff, 0);
    push_cmd(ACT_INSERT, 0, -32'sd1, 0);
    push_cmd(ACT_INSERT, 1, 32'sd0, 0);
    push_cmd(ACT_INSERT, 4, 32'sd5, 0);
    for (k = 5; k < CAPACITY; k++) push_cmd(ACT_INSERT, (k * 7) % (k + 1), k % 3, 0);
    // Full list beats a bad position; find first of duplicates, and a miss.
    push_cmd(ACT_INSERT, 20, 32'sd9, 0);
    push_cmd(ACT_FIND, 0, 32'sd1, 0);
    push_cmd(ACT_FIND, 0, 32'sh1234_5678, 0);
    push_cmd(ACT_FIND, 0, 32'sh8000_0000, 0);
    push_cmd(ACT_READ, CAPACITY - 1, 32'sd0, 0);
    push_cmd(ACT_READ, CAPACITY, 32'sd0, 0);
    // Pop back and front, then erase past the end.
    push_cmd(ACT_ERASE, CAPACITY - 1, 32'sd0, 0);
    push_cmd(ACT_ERASE, 0, 32'sd0, 0);
    push_cmd(ACT_ERASE, CAPACITY, 32'sd0, 0);

    // Random: four phases of sender pacing. The receiver cannot stall, so
    // its phase runs at full rate and the shared phase idles the sender only.
    mode = 0;
    for (n = 0; n < 600; n++) begin
      phase    = n / 150;
      idle_pct = (phase == 1) ? 55 : (phase == 3) ? 30 : 0;
      // Switch between growing, shrinking and steady episodes so the list
      // sweeps from empty to full and back many times.
      if (n % 40 == 0) mode = $urandom_range(2);
      ins_pct = (mode == 0) ? 65 : (mode == 1) ? 15 : 35;
      ers_pct = (mode == 0) ? 15 : (mode == 1) ? 60 : 30;
      roll = $urandom_range(99);
      if (roll < ins_pct) a = ACT_INSERT;
      else if (roll < ins_pct + ers_pct) a = ACT_ERASE;
      else if (roll < ins_pct + ers_pct + (100 - ins_pct - ers_pct) / 2) a = ACT_FIND;
      else a = ACT_READ;
      // Mostly legal positions, some at the boundary, some anywhere in the field.
      roll = $urandom_range(99);
      if (roll < 80) begin
        if (a == ACT_INSERT) p = $urandom_range(gen_len);
        else p = (gen_len > 0) ? $urandom_range(gen_len - 1) : 0;
      end else if (roll < 90) begin
        p = gen_len;
      end else begin
        p = $urandom_range((1 << POS_W) - 1);
      end
      v = ($urandom_range(99) < 70) ? hot_vals[$urandom_range(7)] : $urandom;
      g = 0;
      while (idle_pct > 0 && g < MAX_GAP && $urandom_range(99) < idle_pct) g++;
      push_cmd(a, p, v, g);
    end
    n_items = cmd_q.size();

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every command taken and every result back, then keep watching for a stray strobe.
    do @(negedge clk); while (n_taken != n_items || resp_q.size() != 0);
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
